@@ rtl/core/onmt_pkg.sv @@
// onmt_pkg: shared types and constants for the ordered name table.
// No dependencies; imported by every module of the block.
package onmt_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int NAME_BYTES_DEF = 32;
	localparam int WORD_W         = 64;
	localparam int NAME_W         = 4 * WORD_W;
	localparam int STATUS_W       = 3;
	localparam int POS_W          = 7;

	typedef logic [NAME_W-1:0] name_t;

	typedef enum logic [1:0] {
		MODE_CREATE = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_LIST   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef struct packed {
		logic rotate;
		logic compact;
		logic insert;
	} chain_ctl_t;

endpackage

@@ rtl/core/onmt_cell.sv @@
// onmt_cell: one table slot, loads its neighbor's entry when enabled.
// Depends on onmt_pkg.
module onmt_cell
	import onmt_pkg::*;
(
	input  logic  clk,
	input  logic  load,
	input  name_t next_entry,
	output name_t entry
);

	name_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/core/onmt_chain.sv @@
// onmt_chain: row of onmt_cell slots; rotates toward cell 0 or compacts at and above an index.
// Depends on onmt_pkg and onmt_cell.
module onmt_chain
	import onmt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  chain_ctl_t       ctl,
	input  logic [IDX_W-1:0] hit_idx,
	input  name_t            key,
	output name_t            head
);

	name_t entry [DEPTH];
	name_t tail_in;

	// tail takes the head back, or the new key on insert
	assign tail_in = ctl.insert ? key : entry[0];
	assign head    = entry[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic  load;
		name_t next_entry;

		assign load = ctl.rotate | (ctl.compact & (IDX_W'(i) >= hit_idx));

		if (i < DEPTH - 1) begin : g_mid
			assign next_entry = entry[i+1];
		end else begin : g_end
			assign next_entry = tail_in;
		end

		onmt_cell u_cell (
			.clk        (clk),
			.load       (load),
			.next_entry (next_entry),
			.entry      (entry[i])
		);
	end

endmodule

@@ rtl/core/ordered_name_table.sv @@
// ordered_name_table: top level, command sequencer and result register.
// Depends on onmt_pkg and onmt_chain.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------------
//  in      | in_valid  | in_stall  | mode, name_word0..3
//  out     | out_valid | out_stall | status, position, out_word0..3, last
//
// Every command rotates the cell chain once through its head compare.
// Reset clears the entry count and all control; entry contents stay undefined.
// A result waits in the output register; the scan holds while a list result is stalled.
module ordered_name_table
	import onmt_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int NAME_BYTES = NAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [WORD_W-1:0]   name_word0,
	input  logic [WORD_W-1:0]   name_word1,
	input  logic [WORD_W-1:0]   name_word2,
	input  logic [WORD_W-1:0]   name_word3,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [POS_W-1:0]    position,
	output logic [WORD_W-1:0]   out_word0,
	output logic [WORD_W-1:0]   out_word1,
	output logic [WORD_W-1:0]   out_word2,
	output logic [WORD_W-1:0]   out_word3,
	output logic                last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMPACT,
		S_RESP
	} state_t;

	state_t           state_q;
	mode_t            mode_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic             found_q;
	logic             ins_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] hit_idx_q;
	name_t            key_q;
	name_t            canon;
	name_t            head;
	chain_ctl_t       ctl;

	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]    position_q;
	name_t               out_name_q;
	logic                last_q;

	logic             accept;
	logic             last_step;
	logic [CNT_W-1:0] step_p1;
	logic             live;
	logic             match;
	logic             found_nx;
	logic             ins_now;
	logic             emit;
	logic             out_free;
	logic             adv;
	logic             load_list;
	logic             load_resp;
	status_t          resp_status;
	logic [POS_W-1:0] resp_pos;

	// name ends at first zero byte or at NAME_BYTES
	always_comb begin
		name_t raw;
		logic  ended;
		raw   = {name_word3, name_word2, name_word1, name_word0};
		ended = 1'b0;
		canon = '0;
		for (int b = 0; b < NAME_W / 8; b++) begin
			ended = ended | (raw[b*8 +: 8] == 8'd0) | (b >= NAME_BYTES);
			canon[b*8 +: 8] = ended ? 8'd0 : raw[b*8 +: 8];
		end
	end

	assign accept    = (state_q == S_IDLE) && in_valid;
	assign in_stall  = (state_q != S_IDLE);
	assign last_step = (step_q == IDX_W'(DEPTH - 1));
	assign step_p1   = CNT_W'(step_q) + CNT_W'(1);
	assign live      = (CNT_W'(step_q) < count_q);
	assign match     = live && (head == key_q);
	assign found_nx  = found_q | match;
	assign ins_now   = (mode_q == MODE_CREATE) && (CNT_W'(step_q) == count_q) && !found_q;
	assign emit      = (state_q == S_SCAN) && (mode_q == MODE_LIST) && live;
	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = (state_q == S_SCAN) && (!emit || out_free);
	assign load_list = adv && emit;
	assign load_resp = (state_q == S_RESP) && out_free;

	assign ctl.rotate  = adv;
	assign ctl.insert  = adv && ins_now;
	assign ctl.compact = (state_q == S_COMPACT);

	always_comb begin
		resp_pos = '0;
		unique case (mode_q)
			MODE_CREATE: resp_status = found_q ? ST_EXISTS : (ins_q ? ST_OK : ST_FULL);
			MODE_DELETE: resp_status = found_q ? ST_OK : ST_NOT_FOUND;
			MODE_SEARCH: begin
				resp_status = found_q ? ST_OK : ST_NOT_FOUND;
				if (found_q) begin
					resp_pos = POS_W'(hit_idx_q) + POS_W'(1);
				end
			end
			MODE_LIST:   resp_status = ST_EMPTY;
			default:     resp_status = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_CREATE;
			step_q      <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			ins_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_list || load_resp) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode_t'(mode);
						step_q  <= '0;
						found_q <= 1'b0;
						ins_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (adv) begin
						found_q <= found_nx;
						if (ins_now) begin
							ins_q <= 1'b1;
						end
						if (last_step) begin
							if (ins_now || ins_q) begin
								count_q <= count_q + CNT_W'(1);
							end
							if ((mode_q == MODE_DELETE) && found_nx) begin
								state_q <= S_COMPACT;
							end else if ((mode_q == MODE_LIST) && (count_q != '0)) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RESP;
							end
						end else begin
							step_q <= step_q + IDX_W'(1);
						end
					end
				end
				S_COMPACT: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= canon;
		end
		if (adv && match && !found_q) begin
			hit_idx_q <= step_q;
		end
		if (load_list) begin
			status_q   <= ST_OK;
			position_q <= POS_W'(step_p1);
			out_name_q <= head;
			last_q     <= (step_p1 == count_q);
		end else if (load_resp) begin
			status_q   <= resp_status;
			position_q <= resp_pos;
			out_name_q <= '0;
			last_q     <= 1'b1;
		end
	end

	onmt_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.hit_idx (hit_idx_q),
		.key     (key_q),
		.head    (head)
	);

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign out_word0 = out_name_q[0*WORD_W +: WORD_W];
	assign out_word1 = out_name_q[1*WORD_W +: WORD_W];
	assign out_word2 = out_name_q[2*WORD_W +: WORD_W];
	assign out_word3 = out_name_q[3*WORD_W +: WORD_W];
	assign last      = last_q;

endmodule

@@ rtl/core/onmt_check.sv @@
// onmt_check: port-level assertions for ordered_name_table, bound to the top level.
// Depends on onmt_pkg.
module onmt_check
	import onmt_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [POS_W-1:0]    position,
	input logic                last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new transaction taken while a command runs");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && (position == '0))
		else $error("error result not final or has a position");

	a_list_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (status == ST_OK) && (position != '0))
		else $error("non-final result is not a listed entry");

endmodule

bind ordered_name_table onmt_check u_onmt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.position  (position),
	.last      (last)
);
